// File: rtl/core/setq_pkg.sv
// setq_pkg: shared types and codes for the sorted expiry timer queue
// holds the request, status and sequencer state codes and the result struct
// depends on nothing
`default_nettype none

package setq_pkg;

  // slot id space is fixed by the 4-bit timer id field
  localparam int unsigned ID_W      = 4;
  localparam int unsigned ID_COUNT  = 16;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned FIELD_T_W = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_ADJUST = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_TICK   = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_NOT_PRESENT = 3'd2,
    ST_ALREADY     = 3'd3,
    ST_EXPIRED     = 3'd4,
    ST_NONE_DUE    = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RM_RD,
    S_RM_CHK,
    S_RM_END,
    S_IN_CHK,
    S_IN_RDE,
    S_IN_CMP,
    S_IN_PUT,
    S_TK_RD0,
    S_TK_RDE,
    S_TK_CMP,
    S_TK_POP,
    S_EMIT
  } state_e;

  typedef struct packed {
    status_e         status;
    logic [ID_W-1:0] id;
    logic            last;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/setq_ram.sv
// setq_ram: simple dual port memory, one write and one registered read per cycle
// used for the ordered id list and the per-id expiry store
// depends on nothing
`default_nettype none

module setq_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds its data when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sorted_expiry_timer_queue.sv
// sorted_expiry_timer_queue: top level of the ascending sorted timer list
// depends on setq_pkg and setq_ram (order list and expiry store)
`default_nettype none

// Keeps up to min(DEPTH, 16) timers sorted by expiry, one per 4-bit slot id.
// Requests: add, adjust (remove and re-insert under the new expiry), delete,
// and tick, which pops every head timer due at now_time and gives one item
// per popped id, the final one marked last, or one none-expired item. One
// request is worked at a time by a sequencer that walks the order list in
// memory one entry per step, reusing a single expiry comparator; in_stall_o
// is high until the request's last result has been handed to the output
// register. Add walks from the tail past every entry with a later expiry;
// adjust and delete first scan the whole list to remove the id, adjust
// then walks the remaining entries to re-insert it; a tick re-reads the
// head after each pop, and each pop is a removal scan. A rejected request
// needs no walk at all. Each emitted item waits while the output register
// holds an item that is not taken (out_valid_o and out_stall_i high).
// There is no clearing pass after reset: only the state and return state,
// present bits, entry count, found and pending flags and output valid are reset.
module sorted_expiry_timer_queue #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [setq_pkg::REQ_W-1:0]         req_type_i,
  input  wire logic [setq_pkg::ID_W-1:0]          timer_id_i,
  input  wire logic [setq_pkg::FIELD_T_W-1:0]     expire_time_i,
  input  wire logic [setq_pkg::FIELD_T_W-1:0]     now_time_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [setq_pkg::STATUS_W-1:0]      status_o,
  output logic      [setq_pkg::ID_W-1:0]          expired_id_o,
  output logic                                    last_o
);

  localparam int unsigned IdCount = setq_pkg::ID_COUNT;
  localparam int unsigned Cap     = (DEPTH < IdCount) ? DEPTH : IdCount;
  localparam int unsigned IdxW    = $clog2(Cap);
  localparam int unsigned CntW    = $clog2(Cap + 1);
  localparam int unsigned IdW     = setq_pkg::ID_W;

  setq_pkg::state_e state_q, state_d, ret_q, ret_d;
  setq_pkg::req_e   op_q, op_d, req_in;
  setq_pkg::res_t   res_q, res_d, out_q;

  logic [IdCount-1:0]   present_q, present_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      i_q, i_d, j_q, j_d;
  logic                 found_q, found_d;
  logic                 pend_q, pend_d;
  logic [IdW-1:0]       id_q, id_d;
  logic [TIME_BITS-1:0] key_q, key_d;
  logic                 out_valid_q;

  logic                 in_acc, out_free, lt, due;

  // memory ports
  logic                 ord_we, ord_re;
  logic [IdxW-1:0]      ord_waddr, ord_raddr;
  logic [IdW-1:0]       ord_wdata, ord_rd;
  logic                 exp_we, exp_re;
  logic [IdW-1:0]       exp_raddr;
  logic [TIME_BITS-1:0] exp_rd;

  assign req_in     = setq_pkg::req_e'(req_type_i);
  assign in_stall_o = (state_q != setq_pkg::S_IDLE);
  assign in_acc     = in_valid_i && (state_q == setq_pkg::S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // shared expiry comparator: key below the stored expiry
  assign lt  = key_q < exp_rd;
  assign due = (count_q != '0) && !lt;

  // order list, ids in expiry order
  setq_ram #(
    .WIDTH (IdW),
    .DEPTH (Cap)
  ) u_order (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .re_i    (ord_re),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rd)
  );

  // expiry of each slot id
  setq_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (IdCount)
  ) u_expiry (
    .clk_i   (clk_i),
    .we_i    (exp_we),
    .waddr_i (id_q),
    .wdata_i (key_q),
    .re_i    (exp_re),
    .raddr_i (exp_raddr),
    .rdata_o (exp_rd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      setq_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (req_in)
            setq_pkg::REQ_ADD: begin
              if (present_q[timer_id_i] || (count_q >= CntW'(Cap))) begin
                state_d = setq_pkg::S_EMIT;
              end else begin
                state_d = setq_pkg::S_IN_CHK;
              end
            end
            setq_pkg::REQ_ADJUST, setq_pkg::REQ_DELETE: begin
              state_d = present_q[timer_id_i] ? setq_pkg::S_RM_RD : setq_pkg::S_EMIT;
            end
            setq_pkg::REQ_TICK: state_d = setq_pkg::S_TK_RD0;
          endcase
        end
      end
      setq_pkg::S_RM_RD:  state_d = (i_q == count_q) ? setq_pkg::S_RM_END : setq_pkg::S_RM_CHK;
      setq_pkg::S_RM_CHK: state_d = setq_pkg::S_RM_RD;
      setq_pkg::S_RM_END: begin
        unique case (op_q)
          setq_pkg::REQ_ADJUST: state_d = setq_pkg::S_IN_CHK;
          setq_pkg::REQ_TICK:   state_d = setq_pkg::S_TK_RD0;
          setq_pkg::REQ_ADD,
          setq_pkg::REQ_DELETE: state_d = setq_pkg::S_EMIT;
        endcase
      end
      setq_pkg::S_IN_CHK: state_d = (j_q == '0) ? setq_pkg::S_IN_PUT : setq_pkg::S_IN_RDE;
      setq_pkg::S_IN_RDE: state_d = setq_pkg::S_IN_CMP;
      setq_pkg::S_IN_CMP: state_d = lt ? setq_pkg::S_IN_CHK : setq_pkg::S_IN_PUT;
      setq_pkg::S_IN_PUT: state_d = setq_pkg::S_EMIT;
      setq_pkg::S_TK_RD0: state_d = setq_pkg::S_TK_RDE;
      setq_pkg::S_TK_RDE: state_d = setq_pkg::S_TK_CMP;
      setq_pkg::S_TK_CMP: state_d = (pend_q || !due) ? setq_pkg::S_EMIT : setq_pkg::S_TK_POP;
      setq_pkg::S_TK_POP: state_d = setq_pkg::S_RM_RD;
      setq_pkg::S_EMIT:   state_d = out_free ? ret_q : setq_pkg::S_EMIT;
      default:            state_d = setq_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    op_d      = op_q;
    ret_d     = ret_q;
    res_d     = res_q;
    present_d = present_q;
    count_d   = count_q;
    i_d       = i_q;
    j_d       = j_q;
    found_d   = found_q;
    pend_d    = pend_q;
    id_d      = id_q;
    key_d     = key_q;
    ord_we    = 1'b0;
    ord_re    = 1'b0;
    ord_waddr = i_q[IdxW-1:0];
    ord_raddr = i_q[IdxW-1:0];
    ord_wdata = ord_rd;
    exp_we    = 1'b0;
    exp_re    = 1'b0;
    exp_raddr = ord_rd;
    unique case (state_q)
      setq_pkg::S_IDLE: begin
        if (in_acc) begin
          op_d    = req_in;
          id_d    = timer_id_i;
          key_d   = (req_in == setq_pkg::REQ_TICK) ? TIME_BITS'(now_time_i)
                                                   : TIME_BITS'(expire_time_i);
          ret_d   = setq_pkg::S_IDLE;
          i_d     = '0;
          j_d     = count_q;
          found_d = 1'b0;
          pend_d  = 1'b0;
          res_d   = '{status: setq_pkg::ST_OK, id: '0, last: 1'b1};
          unique case (req_in)
            setq_pkg::REQ_ADD: begin
              if (present_q[timer_id_i]) begin
                res_d.status = setq_pkg::ST_ALREADY;
              end else if (count_q >= CntW'(Cap)) begin
                res_d.status = setq_pkg::ST_FULL;
              end
            end
            setq_pkg::REQ_ADJUST, setq_pkg::REQ_DELETE: begin
              if (!present_q[timer_id_i]) begin
                res_d.status = setq_pkg::ST_NOT_PRESENT;
              end
            end
            setq_pkg::REQ_TICK: ;
          endcase
        end
      end
      // removal scan: find the id, then pull later entries one place forward
      setq_pkg::S_RM_RD: begin
        ord_re    = (i_q != count_q);
        ord_raddr = i_q[IdxW-1:0];
      end
      setq_pkg::S_RM_CHK: begin
        if (found_q) begin
          ord_we    = 1'b1;
          ord_waddr = IdxW'(i_q - CntW'(1));
          ord_wdata = ord_rd;
        end else if (ord_rd == id_q) begin
          found_d = 1'b1;
        end
        i_d = i_q + CntW'(1);
      end
      setq_pkg::S_RM_END: begin
        count_d = count_q - CntW'(1);
        j_d     = count_q - CntW'(1);
        if (op_q == setq_pkg::REQ_DELETE) begin
          present_d[id_q] = 1'b0;
        end
      end
      // insertion walk from the tail: shift later expiries back by one
      setq_pkg::S_IN_CHK: begin
        ord_re    = (j_q != '0);
        ord_raddr = IdxW'(j_q - CntW'(1));
      end
      setq_pkg::S_IN_RDE: begin
        exp_re    = 1'b1;
        exp_raddr = ord_rd;
      end
      setq_pkg::S_IN_CMP: begin
        if (lt) begin
          ord_we    = 1'b1;
          ord_waddr = j_q[IdxW-1:0];
          ord_wdata = ord_rd;
          j_d       = j_q - CntW'(1);
        end
      end
      setq_pkg::S_IN_PUT: begin
        ord_we        = 1'b1;
        ord_waddr     = j_q[IdxW-1:0];
        ord_wdata     = id_q;
        exp_we        = 1'b1;
        count_d       = count_q + CntW'(1);
        present_d[id_q] = 1'b1;
      end
      // tick: look at the head timer
      setq_pkg::S_TK_RD0: begin
        ord_re    = 1'b1;
        ord_raddr = '0;
      end
      setq_pkg::S_TK_RDE: begin
        exp_re    = 1'b1;
        exp_raddr = ord_rd;
      end
      setq_pkg::S_TK_CMP: begin
        if (pend_q) begin
          // the previous pop is reported once we know whether another follows
          res_d = '{status: setq_pkg::ST_EXPIRED, id: id_q, last: !due};
          ret_d = due ? setq_pkg::S_TK_POP : setq_pkg::S_IDLE;
        end else begin
          res_d = '{status: setq_pkg::ST_NONE_DUE, id: '0, last: 1'b1};
          ret_d = setq_pkg::S_IDLE;
        end
      end
      setq_pkg::S_TK_POP: begin
        id_d             = ord_rd;
        present_d[ord_rd] = 1'b0;
        pend_d           = 1'b1;
        i_d              = '0;
        found_d          = 1'b0;
      end
      setq_pkg::S_EMIT: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= setq_pkg::S_IDLE;
      ret_q     <= setq_pkg::S_IDLE;
      present_q <= '0;
      count_q   <= '0;
      found_q   <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      present_q <= present_d;
      count_q   <= count_d;
      found_q   <= found_d;
      pend_q    <= pend_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    res_q <= res_d;
    i_q   <= i_d;
    j_q   <= j_d;
    id_q  <= id_d;
    key_q <= key_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == setq_pkg::S_EMIT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == setq_pkg::S_EMIT) && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign expired_id_o = out_q.id;
  assign last_o       = out_q.last;

`ifndef SYNTHESIS
  // list never grows past its capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Cap))
    else $error("entry count above capacity");

  // between requests the present bits agree with the entry count
  a_present_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == setq_pkg::S_IDLE) |-> ($countones(present_q) == int'(count_q)))
    else $error("present bits and entry count disagree");

  // a removal scan always finds its id
  a_rm_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == setq_pkg::S_RM_END) |-> found_q)
    else $error("removal scan ended without finding the id");

  // an insertion always has room
  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == setq_pkg::S_IN_PUT) |-> (count_q < CntW'(Cap)))
    else $error("insertion into a full list");
`endif

endmodule

`default_nettype wire

// File: bench/sorted_expiry_timer_queue_tb.sv
// sorted_expiry_timer_queue_tb: self-checking bench for the sorted expiry timer queue
// predicts every result from its own timer list and compares each output item
// depends on setq_pkg and sorted_expiry_timer_queue
`timescale 1ns / 100ps

module sorted_expiry_timer_queue_tb;

  localparam int unsigned TIMER_SLOTS = 16;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned ID_BITS = setq_pkg::ID_W;
  localparam int unsigned T_BITS = setq_pkg::FIELD_T_W;

  // clock, reset and block ports
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [setq_pkg::REQ_W-1:0] req_type_i = setq_pkg::REQ_TICK;
  logic [ID_BITS-1:0] timer_id_i = '0;
  logic [T_BITS-1:0] expire_time_i = '0;
  logic [T_BITS-1:0] now_time_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [setq_pkg::STATUS_W-1:0] status_o;
  logic [ID_BITS-1:0] expired_id_o;
  logic last_o;

  // predicted timer list and awaited results
  logic [ID_BITS-1:0] sorted_ids[$];
  logic [T_BITS-1:0] expiry_of[TIMER_SLOTS];
  logic is_listed[TIMER_SLOTS];
  setq_pkg::res_t awaited_results[$];

  // run bookkeeping
  int error_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int timers_expired = 0;
  int receiver_hold = 0;
  bit quiet_tail = 1'b0;
  logic [T_BITS-1:0] clock_base = '0;

  sorted_expiry_timer_queue uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .timer_id_i   (timer_id_i),
    .expire_time_i(expire_time_i),
    .now_time_i   (now_time_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .expired_id_o (expired_id_o),
    .last_o       (last_o)
  );

  always #10 clk_i = ~clk_i;

  // one line per mismatch
  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    error_count++;
    $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  function automatic void push_result(input setq_pkg::status_e st,
                                      input logic [ID_BITS-1:0] id, input logic last);
    setq_pkg::res_t r;
    r.status = st;
    r.id = id;
    r.last = last;
    awaited_results.push_back(r);
  endfunction

  function automatic void unlink_timer(input logic [ID_BITS-1:0] id);
    for (int i = 0; i < sorted_ids.size(); i++) begin
      if (sorted_ids[i] == id) begin
        sorted_ids.delete(i);
        return;
      end
    end
  endfunction

  // goes behind every timer with an equal or earlier expiry
  function automatic void link_timer(input logic [ID_BITS-1:0] id, input logic [T_BITS-1:0] t);
    int pos;
    pos = 0;
    while (pos < sorted_ids.size() && expiry_of[sorted_ids[pos]] <= t) pos++;
    sorted_ids.insert(pos, id);
    expiry_of[id] = t;
  endfunction

  // work out the results of one accepted request
  function automatic void apply_timer_request(input setq_pkg::req_e req,
                                              input logic [ID_BITS-1:0] id,
                                              input logic [T_BITS-1:0] exp_t,
                                              input logic [T_BITS-1:0] now_t);
    logic [ID_BITS-1:0] head;
    setq_pkg::res_t tail;
    int popped;
    popped = 0;
    case (req)
      setq_pkg::REQ_ADD: begin
        if (is_listed[id]) begin
          push_result(setq_pkg::ST_ALREADY, '0, 1'b1);
        end else if (sorted_ids.size() >= TIMER_SLOTS) begin
          push_result(setq_pkg::ST_FULL, '0, 1'b1);
        end else begin
          link_timer(id, exp_t);
          is_listed[id] = 1'b1;
          push_result(setq_pkg::ST_OK, '0, 1'b1);
        end
      end
      setq_pkg::REQ_ADJUST: begin
        if (!is_listed[id]) begin
          push_result(setq_pkg::ST_NOT_PRESENT, '0, 1'b1);
        end else begin
          unlink_timer(id);
          link_timer(id, exp_t);
          push_result(setq_pkg::ST_OK, '0, 1'b1);
        end
      end
      setq_pkg::REQ_DELETE: begin
        if (!is_listed[id]) begin
          push_result(setq_pkg::ST_NOT_PRESENT, '0, 1'b1);
        end else begin
          unlink_timer(id);
          is_listed[id] = 1'b0;
          push_result(setq_pkg::ST_OK, '0, 1'b1);
        end
      end
      default: begin
        while (sorted_ids.size() > 0 && popped < TIMER_SLOTS) begin
          head = sorted_ids[0];
          if (now_t < expiry_of[head]) break;
          void'(sorted_ids.pop_front());
          is_listed[head] = 1'b0;
          push_result(setq_pkg::ST_EXPIRED, head, 1'b0);
          popped++;
        end
        if (popped == 0) begin
          push_result(setq_pkg::ST_NONE_DUE, '0, 1'b1);
        end else begin
          tail = awaited_results.pop_back();
          tail.last = 1'b1;
          awaited_results.push_back(tail);
          timers_expired += popped;
        end
      end
    endcase
  endfunction

  // offer one item, hold it until accepted, then predict its results
  task automatic send_request(input setq_pkg::req_e req, input logic [ID_BITS-1:0] id,
                              input logic [T_BITS-1:0] exp_t,
                              input logic [T_BITS-1:0] now_t);
    int gap;
    gap = 0;
    if (!quiet_tail && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 13);
    repeat (gap) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    req_type_i = req;
    timer_id_i = id;
    expire_time_i = exp_t;
    now_time_i = now_t;
    do @(posedge clk_i); while (in_stall_o);
    apply_timer_request(req, id, exp_t, now_t);
    items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // sender pause until every awaited result is back
  task automatic wait_results_drained();
    while (awaited_results.size() > 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver stall: long hold-off first, then random bursts unless in the quiet tail
  initial begin
    int burst_left;
    burst_left = 0;
    forever begin
      @(negedge clk_i);
      if (receiver_hold > 0) begin
        receiver_hold--;
        out_stall_i = 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall_i = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(1, 13) - 1;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // compare each accepted output item with the oldest awaited result
  always @(posedge clk_i) begin
    setq_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result, status", 0, status_o);
      end else begin
        want = awaited_results.pop_front();
        if (status_o !== want.status) report_mismatch("status", want.status, status_o);
        if (expired_id_o !== want.id) report_mismatch("expired_id", want.id, expired_id_o);
        if (last_o !== want.last) report_mismatch("last", want.last, last_o);
      end
    end
  end

  // empty list, absent ids, duplicates, ties, earlier and later adjusts, time extremes
  task automatic test_directed_cases();
    send_request(setq_pkg::REQ_TICK, 4'd0, '0, 32'd0);
    send_request(setq_pkg::REQ_DELETE, 4'd3, '0, '0);
    send_request(setq_pkg::REQ_ADJUST, 4'd3, 32'd10, '0);
    send_request(setq_pkg::REQ_ADD, 4'd0, 32'd0, '0);
    send_request(setq_pkg::REQ_ADD, 4'd15, 32'hFFFF_FFFF, '0);
    send_request(setq_pkg::REQ_ADD, 4'd5, 32'd100, '0);
    send_request(setq_pkg::REQ_ADD, 4'd6, 32'd100, '0);
    send_request(setq_pkg::REQ_ADD, 4'd5, 32'd7, '0);
    send_request(setq_pkg::REQ_ADJUST, 4'd5, 32'd100, '0);
    send_request(setq_pkg::REQ_ADJUST, 4'd15, 32'd50, '0);
    send_request(setq_pkg::REQ_TICK, '0, '0, 32'd0);
    send_request(setq_pkg::REQ_ADD, 4'd0, 32'd200, '0);
    send_request(setq_pkg::REQ_ADJUST, 4'd0, 32'd300, '0);
    send_request(setq_pkg::REQ_DELETE, 4'd6, '0, '0);
    send_request(setq_pkg::REQ_DELETE, 4'd6, '0, '0);
    send_request(setq_pkg::REQ_TICK, '0, '0, 32'd49);
    send_request(setq_pkg::REQ_TICK, '0, '0, 32'd100);
    send_request(setq_pkg::REQ_TICK, '0, '0, 32'hFFFF_FFFE);
    send_request(setq_pkg::REQ_ADD, 4'd9, 32'hFFFF_FFFF, '0);
    send_request(setq_pkg::REQ_TICK, '0, '0, 32'hFFFF_FFFF);
    send_request(setq_pkg::REQ_TICK, '0, '0, 32'hFFFF_FFFF);
    send_request(setq_pkg::REQ_DELETE, 4'd15, '0, '0);
    send_request(setq_pkg::REQ_ADD, 4'd12, 32'd0, '0);
    send_request(setq_pkg::REQ_ADJUST, 4'd12, 32'hFFFF_FFFF, '0);
    send_request(setq_pkg::REQ_DELETE, 4'd12, '0, '0);
  endtask

  // fill every slot behind a long receiver hold-off, then pop all of them in one tick
  task automatic test_full_list_flush();
    logic [ID_BITS-1:0] slots[$];
    int pick;
    for (int i = 0; i < TIMER_SLOTS; i++) slots.push_back(i[ID_BITS-1:0]);
    receiver_hold = 300;
    while (slots.size() > 0) begin
      pick = $urandom_range(0, slots.size() - 1);
      send_request(setq_pkg::REQ_ADD, slots[pick], $urandom_range(0, 7) * 1000, '0);
      slots.delete(pick);
    end
    // every id is listed, so a further add reports the id as present
    send_request(setq_pkg::REQ_ADD, ID_BITS'($urandom_range(0, 15)), 32'd5, '0);
    send_request(setq_pkg::REQ_ADJUST, ID_BITS'($urandom_range(0, 15)), 32'd3500, '0);
    send_request(setq_pkg::REQ_TICK, '0, '0, 32'hFFFF_FFFF);
  endtask

  // random traffic around a moving current time, with some fully random noise
  task automatic test_random_traffic(input int count);
    setq_pkg::req_e req;
    logic [ID_BITS-1:0] id;
    logic [T_BITS-1:0] exp_t;
    logic [T_BITS-1:0] now_t;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      id = ID_BITS'($urandom_range(0, 15));
      exp_t = clock_base + $urandom_range(0, 400);
      now_t = clock_base;
      if (pick < 40) begin
        req = setq_pkg::REQ_ADD;
      end else if (pick < 55) begin
        req = setq_pkg::REQ_ADJUST;
      end else if (pick < 65) begin
        req = setq_pkg::REQ_DELETE;
      end else begin
        req = setq_pkg::REQ_TICK;
        clock_base = clock_base + $urandom_range(0, 120);
        now_t = clock_base;
      end
      // adjust and delete mostly target a listed timer
      if ((req == setq_pkg::REQ_ADJUST || req == setq_pkg::REQ_DELETE) &&
          sorted_ids.size() > 0 && $urandom_range(0, 3) != 0)
        id = sorted_ids[$urandom_range(0, sorted_ids.size() - 1)];
      if ($urandom_range(0, 9) == 0) begin
        exp_t = $urandom();
        now_t = $urandom();
      end
      send_request(req, id, exp_t, now_t);
    end
  endtask

  initial begin
    int drain_cycles;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      is_listed[i] = 1'b0;
      expiry_of[i] = '0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    wait_results_drained();
    test_full_list_flush();
    wait_results_drained();
    clock_base = $urandom_range(0, 1000);
    test_random_traffic(56);
    wait_results_drained();
    clock_base = 32'hFFFF_F000 + $urandom_range(0, 1000);
    test_random_traffic(40);
    quiet_tail = 1'b1;
    test_random_traffic(40);

    // let the last results come out, then settle
    drain_cycles = 0;
    while (awaited_results.size() > 0 && drain_cycles < 20000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (awaited_results.size() > 0)
      report_mismatch("results never delivered", 0, awaited_results.size());

    $display("covered: directed edge cases, full list flush under output hold-off, random traffic");
    $display("%0d requests sent, %0d results checked, %0d timers expired, %0d mismatches",
             items_sent, results_seen, timers_expired, error_count);
    if (error_count == 0) begin
      $display("sorted_expiry_timer_queue verification clean");
    end else begin
      $display("sorted_expiry_timer_queue verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", awaited_results.size());
    $display("sorted_expiry_timer_queue verification failed");
    $finish;
  end

endmodule
